### rtl/bba_pkg.sv
// Shared types, constants and helper functions of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int WORD_BITS   = 32;
  localparam int SIZE_W      = 20;
  localparam int BLOCK_W     = 15;
  localparam int RUN_W       = 16;
  localparam int OFFSET_W    = 20;
  localparam int LEFT_W      = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NO_ROOM = 1'b1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_EX   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    M_SCAN = 4'b0001,
    M_TEST = 4'b0010,
    M_SET  = 4'b0100,
    M_CLR  = 4'b1000
  } mode_t;

  function automatic logic [5:0] count_ones(input logic [31:0] w);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      n = n + 6'(w[k]);
    end
    return n;
  endfunction

  // Returns the lowest zero bit at or above from, or 32 when there is none.
  function automatic logic [5:0] low_zero_from(input logic [31:0] w, input logic [4:0] from);
    logic [31:0] v;
    logic [5:0]  r;
    v = w | ((32'h1 << from) - 32'h1);
    r = 6'd32;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!v[k]) begin
        r = 6'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/bba_div.sv
// Reciprocal-multiplication divider by the constant block size.
`timescale 1ns / 1ps
`default_nettype none
module bba_div #(
  parameter int BLOCK_BYTES = 32,
  parameter int SUM_W       = 21,
  parameter int Q_W         = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  output logic                  done,
  output logic [Q_W-1:0]        quotient
);
  localparam int RL = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
  localparam int SH = SUM_W + RL;
  localparam int PW = 2 * SUM_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [SUM_W:0] RECIP_C = (SUM_W+1)'(RECIP);

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= prod[SH +: Q_W];
    end
  end

endmodule
`default_nettype wire

### rtl/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator: sequencer, bitmap memory and result register.
// A first-fit allocator over a pool of POOL_WORDS*32 blocks, each BLOCK_BYTES long, whose busy
// bitmap lives in one synchronous memory of 32-bit words. After reset the block sweeps the
// memory clear, one word a cycle, with s_tready low. An allocate beat first rounds the size
// plus header up to whole blocks with a reciprocal multiplication and checks the count against
// the free blocks, then takes a read step and a test or update step for every bitmap word it
// scans, tests or marks, so its latency grows with how far the search walks through the map. A
// free beat takes a read step and an update step for every bitmap word that the run touches.
// One item is in flight at a time, and its result waits in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_block_allocator_unit #(
  parameter int POOL_WORDS   = 1024,
  parameter int BLOCK_BYTES  = 32,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // size_bytes[19:0], first_block[34:20], run_blocks[50:35], zeros above
  input  wire logic [bba_pkg::IN_TDATA_W-1:0] s_tdata,
  // action
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // start_block[14:0], data_offset[34:15], blocks_left[50:35], zeros above
  output logic [bba_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // status
  output logic                                m_tuser
);
  import bba_pkg::*;

  localparam int WIW   = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int FOW   = $clog2(POOL_WORDS + 1);
  localparam int TOTAL = POOL_WORDS * WORD_BITS;
  localparam int FW    = $clog2(TOTAL + 1);
  localparam int SUMMAX = (1 << SIZE_W) - 1 + HEADER_BYTES + BLOCK_BYTES - 1;
  localparam int SW    = $clog2(SUMMAX + 1);
  localparam int NRW   = $clog2(SUMMAX / BLOCK_BYTES + 1);
  localparam int CW    = (NRW > RUN_W) ? NRW : RUN_W;
  localparam int IW    = FOW + NRW + 1;
  localparam int CMPW  = (FW > NRW) ? FW : NRW;

  state_t state;
  mode_t  mode;

  logic [31:0]      mem [POOL_WORDS];
  logic [31:0]      rd_data;
  logic             mem_we;
  logic [WIW-1:0]   mem_wa;
  logic [31:0]      mem_wd;
  logic [WIW-1:0]   clr_addr;

  logic [FW-1:0]    free_count;
  logic [FOW-1:0]   first_open;
  logic [IW-1:0]    scan_i;
  logic [4:0]       cursor;
  logic [4:0]       idx;
  logic [IW-1:0]    w;
  logic [4:0]       bitpos;
  logic [CW-1:0]    cnt;
  logic [NRW-1:0]   nr;
  logic             granted;

  logic             div_start;
  logic             div_done;
  logic [SW-1:0]    div_sum;
  logic [NRW-1:0]   div_q;

  logic [SIZE_W-1:0]  in_size;
  logic [BLOCK_W-1:0] in_first;
  logic [RUN_W-1:0]   in_run;

  logic [5:0]       room;
  logic [5:0]       take;
  logic [31:0]      mask;
  logic [5:0]       zpos;
  logic [IW-1:0]    next_bit;
  logic [IW+4:0]    start_full;
  logic [OFFSET_W-1:0] off_calc;

  assign in_size  = s_tdata[19:0];
  assign in_first = s_tdata[34:20];
  assign in_run   = s_tdata[50:35];

  assign s_tready  = (state == S_IDLE);
  assign div_start = s_tvalid && s_tready && (s_tuser == ACT_ALLOC);
  assign div_sum   = SW'(in_size) + SW'(HEADER_BYTES + BLOCK_BYTES - 1);

  bba_div #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .SUM_W      (SW),
    .Q_W        (NRW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_sum),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    room = 6'd32 - {1'b0, bitpos};
    take = (cnt < CW'(room)) ? cnt[5:0] : room;
    if (take == 6'd32) begin
      mask = '1;
    end else begin
      mask = ((32'h1 << take[4:0]) - 32'h1) << bitpos;
    end
    zpos       = low_zero_from(rd_data, cursor);
    next_bit   = IW'(idx) + IW'(nr);
    start_full = {scan_i, 5'b0} | (IW+5)'(idx);
    off_calc   = start_full[OFFSET_W-1:0] * OFFSET_W'(BLOCK_BYTES) + OFFSET_W'(HEADER_BYTES);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = w[WIW-1:0];
    mem_wd = rd_data;
    if (state == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == S_EX) begin
      if (mode == M_SET) begin
        mem_we = 1'b1;
        mem_wd = rd_data | mask;
      end else if (mode == M_CLR) begin
        mem_we = 1'b1;
        mem_wd = rd_data & ~mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[w[WIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      mode       <= M_SCAN;
      clr_addr   <= '0;
      free_count <= FW'(TOTAL);
      first_open <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + WIW'(1);
          if (clr_addr == WIW'(POOL_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            granted <= 1'b0;
            if (s_tuser == ACT_FREE) begin
              w      <= IW'(in_first[BLOCK_W-1:5]);
              bitpos <= in_first[4:0];
              cnt    <= CW'(in_run);
              mode   <= M_CLR;
              state  <= S_RD;
              if (in_run != '0 && FOW'(in_first[BLOCK_W-1:5]) < first_open) begin
                first_open <= FOW'(in_first[BLOCK_W-1:5]);
              end
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            nr    <= div_q;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          mode <= M_SCAN;
          if (CMPW'(nr) > CMPW'(free_count)) begin
            state <= S_OUT;
          end else begin
            scan_i <= IW'(first_open);
            w      <= IW'(first_open);
            cursor <= '0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          if (mode != M_SCAN && cnt == '0) begin
            priority case (1'b1)
              mode == M_TEST: begin
                w      <= scan_i;
                bitpos <= idx;
                cnt    <= CW'(nr);
                mode   <= M_SET;
              end
              mode == M_SET: begin
                free_count <= free_count - FW'(nr);
                granted    <= 1'b1;
                state      <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end else if (w >= IW'(POOL_WORDS)) begin
            if (mode == M_TEST) begin
              mode <= M_SCAN;
              if (next_bit < IW'(WORD_BITS)) begin
                cursor <= next_bit[4:0];
                w      <= scan_i;
              end else begin
                cursor <= '0;
                scan_i <= scan_i + (next_bit >> 5);
                w      <= scan_i + (next_bit >> 5);
              end
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_EX;
          end
        end
        S_EX: begin
          state <= S_RD;
          if (mode == M_SCAN) begin
            if (rd_data == '1) begin
              scan_i     <= scan_i + IW'(1);
              w          <= scan_i + IW'(1);
              first_open <= FOW'(scan_i + IW'(1));
              cursor     <= '0;
            end else if (zpos[5]) begin
              scan_i <= scan_i + IW'(1);
              w      <= scan_i + IW'(1);
              cursor <= '0;
            end else begin
              idx    <= zpos[4:0];
              bitpos <= zpos[4:0];
              cnt    <= CW'(nr);
              mode   <= M_TEST;
            end
          end else if (mode == M_TEST && (rd_data & mask) != '0) begin
            mode <= M_SCAN;
            if (next_bit < IW'(WORD_BITS)) begin
              cursor <= next_bit[4:0];
              w      <= scan_i;
            end else begin
              cursor <= '0;
              scan_i <= scan_i + (next_bit >> 5);
              w      <= scan_i + (next_bit >> 5);
            end
          end else begin
            if (mode == M_CLR) begin
              free_count <= free_count + FW'(count_ones(rd_data & mask));
            end
            cnt    <= cnt - CW'(take);
            bitpos <= '0;
            w      <= w + IW'(1);
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= (mode == M_SCAN || mode == M_TEST || !granted) && !(mode == M_CLR)
                 ? ST_NO_ROOM : ST_DONE;
      m_tdata[14:0]  <= granted ? start_full[BLOCK_W-1:0] : '0;
      m_tdata[34:15] <= granted ? off_calc : '0;
      m_tdata[50:35] <= free_count[LEFT_W-1:0];
      m_tdata[55:51] <= '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");
  assert property (@(posedge clk) disable iff (rst) free_count <= FW'(TOTAL))
    else $error("free count exceeds pool size");
  assert property (@(posedge clk) disable iff (rst) mem_we |-> (state == S_EX || state == S_CLR))
    else $error("bitmap written outside update or clearing");
  assert property (@(posedge clk) disable iff (rst) state == S_CLR |-> !s_tready)
    else $error("input accepted during clearing pass");

endmodule
`default_nettype wire
